// File: rtl/mpf_pkg.sv
`timescale 1ns / 1ps
package mpf_pkg;
	localparam int NCH     = 4;
	localparam int PW      = 8;
	localparam int RING    = 6;
	localparam int WIN     = 5;
	localparam int HB      = 12;
	localparam int RB      = 11;
	localparam int H_LIMIT = 2048;

	typedef logic [PW-1:0] pix_t;
	typedef logic [2:0]    slot_t;

	typedef struct packed {
		pix_t lo;
		pix_t hi;
	} mm_t;

	typedef mm_t [NCH-1:0] colmm_t;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_CHANNELS,
		REG_RADIUS
	} cfg_reg_t;

	function automatic slot_t slot_add(slot_t s, logic signed [2:0] d);
		logic [3:0] t;
		t = {1'b0, s} + 4'd6 + {d[2], d};
		if (t >= 4'd12) begin
			t = t - 4'd12;
		end else if (t >= 4'd6) begin
			t = t - 4'd6;
		end
		return t[2:0];
	endfunction

	function automatic slot_t slot_inc(slot_t s);
		return (s == slot_t'(RING - 1)) ? '0 : s + 3'd1;
	endfunction
endpackage

// File: rtl/midpoint_filter_5x5.sv
`timescale 1ns / 1ps
// path: a released result passes the read request, line buffer read, column cells
// and output queue; one that opens an output row waits first for its window fill
// throughput: one item per cycle while output credit lasts; a row's first window takes
// radius+1 line buffer reads, one column per cycle, and input holds off meanwhile
// reset: 640x480, one channel, 3x3 window, counters cleared, line buffers not cleared
module midpoint_filter_5x5 import mpf_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pix_ch0, pix_ch1, pix_ch2, pix_ch3
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int WB    = (AW + 1 > HB) ? AW + 1 : HB;
	localparam int PB    = $clog2(2 * MAX_WIDTH + 3);
	localparam int DEPTH = 8;
	localparam int FB    = $clog2(DEPTH);
	localparam int CB    = FB + 1;

	logic [HB-1:0] w_q, h_q;
	logic [2:0]    ch_q;
	logic [1:0]    rad_q;

	logic [WB-1:0] w_eff;
	logic [HB-1:0] h_eff;
	logic [2:0]    ch_eff;
	logic          r2;
	logic [1:0]    r_eff;
	logic [PB-1:0] lag;

	always_comb begin
		if (w_q == '0) begin
			w_eff = WB'(1);
		end else if (WB'(w_q) > WB'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(w_q);
		end
		if (h_q == '0) begin
			h_eff = HB'(1);
		end else if (h_q > HB'(H_LIMIT)) begin
			h_eff = HB'(H_LIMIT);
		end else begin
			h_eff = h_q;
		end
		if (ch_q == 3'd0) begin
			ch_eff = 3'd1;
		end else if (ch_q > 3'd4) begin
			ch_eff = 3'd4;
		end else begin
			ch_eff = ch_q;
		end
		r2    = (rad_q >= 2'd2) && (MAX_RADIUS >= 2);
		r_eff = r2 ? 2'd2 : 2'd1;
		lag   = r2 ? PB'({w_eff, 1'b0}) + PB'(2) : PB'(w_eff) + PB'(1);
	end

	// stream position
	logic [AW-1:0] in_col_q, out_col_q;
	logic [RB-1:0] in_row_q, out_row_q;
	slot_t         in_slot_q, out_slot_q;
	logic [PB-1:0] pend_q;
	logic [CB-1:0] cnt_q;

	logic acc, pix, emit, cfg_acc, cfg_hit, pop;
	logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

	// read sequencer
	logic          req_v_q;
	logic [AW-1:0] req_col_q;
	logic [RB-1:0] req_row_q;
	slot_t         req_slot_q;
	logic [1:0]    req_idx_q;
	logic          req_last_q;
	logic          row_start, done;
	logic [WB-1:0] c_want, rd_col;
	slot_t         slot_s1 [WIN];

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_acc && (cfg_index[7:2] == 6'd0);
	assign acc       = s_tvalid && s_tready;
	assign pix       = !s_tuser;
	assign pop       = m_tvalid && m_tready;

	assign row_start = (req_col_q == '0);
	assign done      = !row_start || (req_idx_q == r_eff);
	assign s_tready  = (cnt_q < CB'(DEPTH)) && !(req_v_q && !done);

	assign in_col_wrap  = (WB'(in_col_q) + WB'(1)) >= w_eff;
	assign in_row_wrap  = (HB'(in_row_q) + HB'(1)) >= h_eff;
	assign out_col_wrap = (WB'(out_col_q) + WB'(1)) >= w_eff;
	assign out_row_wrap = (HB'(out_row_q) + HB'(1)) >= h_eff;

	always_comb begin
		if (pix) begin
			emit = acc && ((pend_q + PB'(1)) > lag);
		end else begin
			emit = acc && (pend_q != '0) && (in_row_q == '0) && (in_col_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= HB'(640);
			h_q        <= HB'(480);
			ch_q       <= 3'd1;
			rad_q      <= 2'd1;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_reg_t'(cfg_index[1:0]))
				REG_WIDTH:    w_q   <= cfg_data;
				REG_HEIGHT:   h_q   <= cfg_data;
				REG_CHANNELS: ch_q  <= cfg_data[2:0];
				REG_RADIUS:   rad_q <= cfg_data[1:0];
				default:      w_q   <= w_q;
			endcase
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (acc) begin
			if (pix) begin
				if (in_col_wrap) begin
					in_col_q  <= '0;
					in_slot_q <= slot_inc(in_slot_q);
					in_row_q  <= in_row_wrap ? '0 : in_row_q + RB'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end
			if (emit) begin
				if (out_col_wrap) begin
					out_col_q  <= '0;
					out_slot_q <= slot_inc(out_slot_q);
					out_row_q  <= out_row_wrap ? '0 : out_row_q + RB'(1);
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
			if (pix && !emit) begin
				pend_q <= pend_q + PB'(1);
			end else if (!pix && emit) begin
				pend_q <= pend_q - PB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_q   <= 1'b0;
			req_idx_q <= '0;
		end else if (emit) begin
			req_v_q   <= 1'b1;
			req_idx_q <= '0;
		end else if (req_v_q && !done) begin
			req_idx_q <= req_idx_q + 2'd1;
		end else begin
			req_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			req_col_q  <= out_col_q;
			req_row_q  <= out_row_q;
			req_slot_q <= out_slot_q;
			req_last_q <= out_col_wrap && out_row_wrap;
		end
	end

	// column to read and the ring slot of each window row
	always_comb begin
		int                dy;
		logic signed [HB:0] rr;
		logic signed [HB:0] row_s;
		logic signed [HB:0] hmax;
		logic signed [HB:0] d;
		c_want = row_start ? WB'(req_idx_q) : WB'(req_col_q) + WB'(r_eff);
		rd_col = (c_want > w_eff - WB'(1)) ? w_eff - WB'(1) : c_want;
		row_s  = $signed({2'b00, req_row_q});
		hmax   = $signed({1'b0, h_eff - HB'(1)});
		for (int i = 0; i < WIN; i++) begin
			dy = i - 2;
			if (dy > int'(r_eff)) begin
				dy = int'(r_eff);
			end
			if (dy < -int'(r_eff)) begin
				dy = -int'(r_eff);
			end
			rr = row_s + (HB+1)'(dy);
			if (rr < 0) begin
				rr = '0;
			end else if (rr > hmax) begin
				rr = hmax;
			end
			d          = rr - row_s;
			slot_s1[i] = slot_add(req_slot_q, d[2:0]);
		end
	end

	// line buffers, one bank per ring row
	logic [31:0] rdat [RING];

	for (genvar b = 0; b < RING; b++) begin : g_bank
		mpf_ram #(.W(32), .D(MAX_WIDTH)) u_ram (
			.clk   (clk),
			.we    (acc && pix && (in_slot_q == slot_t'(b))),
			.waddr (in_col_q),
			.wdata (s_tdata),
			.raddr (rd_col[AW-1:0]),
			.rdata (rdat[b])
		);
	end

	logic  v_s2, load_s2, fin_s2, last_s2;
	slot_t slots_s2 [WIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= req_v_q;
		end
	end

	always_ff @(posedge clk) begin
		load_s2  <= row_start && (req_idx_q == 2'd0);
		fin_s2   <= done;
		last_s2  <= req_last_q;
		slots_s2 <= slot_s1;
	end

	colmm_t col_mm;

	always_comb begin
		pix_t v;
		for (int k = 0; k < NCH; k++) begin
			col_mm[k].lo = '1;
			col_mm[k].hi = '0;
			for (int i = 0; i < WIN; i++) begin
				v = rdat[slots_s2[i]][PW*k +: PW];
				if (v < col_mm[k].lo) begin
					col_mm[k].lo = v;
				end
				if (v > col_mm[k].hi) begin
					col_mm[k].hi = v;
				end
			end
		end
	end

	colmm_t cell_q [WIN];

	for (genvar c = 0; c < WIN; c++) begin : g_cell
		mpf_cell u_cell (
			.clk      (clk),
			.en       (v_s2),
			.load     (load_s2),
			.fresh    (col_mm),
			.shift_in ((c == WIN - 1) ? col_mm : cell_q[(c + 1) % WIN]),
			.q        (cell_q[c])
		);
	end

	logic v_s3, last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s3 <= last_s2;
	end

	logic [31:0] res;

	// the newest column sits in the last cell, so a 3x3 window uses the last three
	always_comb begin
		pix_t       lo, hi;
		logic [8:0] sum;
		for (int k = 0; k < NCH; k++) begin
			lo = '1;
			hi = '0;
			for (int c = 0; c < WIN; c++) begin
				if (r2 || c >= 2) begin
					if (cell_q[c][k].lo < lo) begin
						lo = cell_q[c][k].lo;
					end
					if (cell_q[c][k].hi > hi) begin
						hi = cell_q[c][k].hi;
					end
				end
			end
			sum = {1'b0, lo} + {1'b0, hi} + 9'd1;
			res[PW*k +: PW] = (3'(k) < ch_eff) ? sum[8:1] : '0;
		end
	end

	// output queue, sized by the credit count
	logic [32:0]   fifo_q [DEPTH];
	logic [FB-1:0] wp_q, rp_q;
	logic [CB-1:0] occ_q;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wp_q] <= {last_s3, res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			occ_q <= '0;
			cnt_q <= '0;
		end else begin
			if (v_s3) begin
				wp_q <= wp_q + FB'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FB'(1);
			end
			occ_q <= occ_q + CB'(v_s3) - CB'(pop);
			cnt_q <= cnt_q + CB'(emit) - CB'(pop);
		end
	end

	assign m_tvalid = (occ_q != '0);
	assign m_tdata  = fifo_q[rp_q][31:0];
	assign m_tlast  = fifo_q[rp_q][32];

	a_occ_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cnt_q) else $error("output queue holds more than was released");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (occ_q < CB'(DEPTH)) || pop) else $error("output queue overflow");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_v_q && !done) |=> req_v_q) else $error("window fill cut short");
endmodule

// File: rtl/mpf_ram.sv
`timescale 1ns / 1ps
module mpf_ram #(
	parameter int W = 32,
	parameter int D = 2048
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/mpf_cell.sv
`timescale 1ns / 1ps
module mpf_cell import mpf_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  logic   load,
	input  colmm_t fresh,
	input  colmm_t shift_in,
	output colmm_t q
);
	colmm_t col_q;

	// load fills the whole row with the left edge column
	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= load ? fresh : shift_in;
		end
	end

	assign q = col_q;
endmodule
